// ===== rtl/bpc_pkg.sv =====
// Package for the button press classifier: sizes, reset values, codes and
// the transaction types passed between the top level and the core.
// No dependencies.
package bpc_pkg;

  localparam int unsigned BUTTONS   = 3;
  localparam int unsigned BTN_IDX_W = 2;
  localparam int unsigned PIN_W     = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned DEB_W     = 8;
  localparam int unsigned CFG_AW    = 2;
  localparam int unsigned CFG_DW    = 16;
  localparam int unsigned S_DATA_W  = 8;
  localparam int unsigned M_DATA_W  = 8;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd10;
  localparam logic [CNT_W-1:0] LONG_RST     = 16'd1500;
  localparam logic [CNT_W-1:0] BLOCK_RST    = 16'd2000;

  typedef enum logic [CFG_AW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_BLOCK    = 2'd2,
    REG_ENABLED  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ACT_TICK   = 1'b0,
    ACT_CHANGE = 1'b1
  } act_e;

  localparam logic PRESS_LONG  = 1'b0;
  localparam logic PRESS_SHORT = 1'b1;
  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  typedef struct packed {
    act_e                 action;
    logic [BTN_IDX_W-1:0] button_index;
    logic                 level;
    logic [PIN_W-1:0]     pin_levels;
  } item_t;

  typedef struct packed {
    logic [BTN_IDX_W-1:0] press_button;
    logic                 press_type;
    logic                 by_timeout;
  } result_t;

  function automatic logic [CNT_W-1:0] start_value(input logic [CNT_W-1:0] v);
    start_value = (v == '0) ? CNT_W'(1) : v;
  endfunction

endpackage

// ===== rtl/bpc_core.sv =====
// Classifier core: configuration registers, per-button state and the
// combinational update for one tick or level-change transaction.
// Depends on bpc_pkg.
module bpc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [bpc_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                          item_valid_i,
  input  bpc_pkg::item_t                item_i,
  output logic                          res_valid_o,
  output bpc_pkg::result_t              res_o
);
  import bpc_pkg::*;

  logic [DEB_W-1:0]  debounce_q, debounce_d;
  logic [CNT_W-1:0]  long_q, long_d;
  logic [CNT_W-1:0]  block_cfg_q, block_cfg_d;
  logic              enabled_q, enabled_d;

  logic [TIME_W-1:0] now_q, now_d;
  logic [BUTTONS-1:0] level_q, level_d;
  logic [BUTTONS-1:0] edge_en_q, edge_en_d;
  logic [TIME_W-1:0] last_q [BUTTONS];
  logic [TIME_W-1:0] last_d [BUTTONS];
  logic [CNT_W-1:0]  hold_q [BUTTONS];
  logic [CNT_W-1:0]  hold_d [BUTTONS];
  logic [CNT_W-1:0]  block_q, block_d;

  always_comb begin
    logic                 found;
    logic [BTN_IDX_W-1:0] exp_idx;
    logic [BTN_IDX_W-1:0] b;
    logic [TIME_W-1:0]    held;

    debounce_d  = debounce_q;
    long_d      = long_q;
    block_cfg_d = block_cfg_q;
    enabled_d   = enabled_q;
    now_d       = now_q;
    level_d     = level_q;
    edge_en_d   = edge_en_q;
    last_d      = last_q;
    hold_d      = hold_q;
    block_d     = block_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    found       = 1'b0;
    exp_idx     = '0;
    b           = item_i.button_index;
    held        = '0;

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_DEBOUNCE: debounce_d  = cfg_wdata_i[DEB_W-1:0];
        REG_LONG:     long_d      = cfg_wdata_i;
        REG_BLOCK:    block_cfg_d = cfg_wdata_i;
        REG_ENABLED: begin
          enabled_d = cfg_wdata_i[0];
          if (cfg_wdata_i[0]) begin
            edge_en_d = '1;
          end
        end
        default: ;
      endcase
    end else if (item_valid_i) begin
      if (item_i.action == ACT_TICK) begin
        now_d = now_q + TIME_W'(1);
        if (block_q != '0) begin
          block_d = block_q - CNT_W'(1);
          if (block_q == CNT_W'(1)) begin
            edge_en_d = '1;
          end
        end
        for (int i = 0; i < BUTTONS; i++) begin
          if (hold_q[i] > CNT_W'(1)) begin
            hold_d[i] = hold_q[i] - CNT_W'(1);
          end else if (hold_q[i] == CNT_W'(1) && !found) begin
            hold_d[i] = '0;
            found     = 1'b1;
            exp_idx   = BTN_IDX_W'(i);
          end
        end
        if (found && item_i.pin_levels[exp_idx] == LVL_PRESSED) begin
          edge_en_d[exp_idx]    = 1'b0;
          level_d[exp_idx]      = LVL_RELEASED;
          block_d               = start_value(block_cfg_q);
          res_valid_o           = 1'b1;
          res_o.press_button    = exp_idx;
          res_o.press_type      = PRESS_LONG;
          res_o.by_timeout      = 1'b1;
        end
      end else if (b < BTN_IDX_W'(BUTTONS)) begin
        if (enabled_q && edge_en_q[b] && item_i.level != level_q[b]) begin
          held = now_q - last_q[b];
          last_d[b] = now_q;
          if (held >= TIME_W'(debounce_q)) begin
            for (int j = 0; j < BUTTONS; j++) begin
              if (BTN_IDX_W'(j) != b) begin
                edge_en_d[j] = 1'b0;
              end
            end
            if (item_i.level == LVL_PRESSED) begin
              level_d[b] = LVL_PRESSED;
              hold_d[b]  = start_value(long_q);
            end else begin
              edge_en_d[b]       = 1'b0;
              level_d[b]         = LVL_RELEASED;
              hold_d[b]          = '0;
              block_d            = start_value(block_cfg_q);
              res_valid_o        = 1'b1;
              res_o.press_button = b;
              res_o.press_type   = (held > TIME_W'(long_q)) ? PRESS_LONG : PRESS_SHORT;
              res_o.by_timeout   = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DEBOUNCE_RST;
      long_q      <= LONG_RST;
      block_cfg_q <= BLOCK_RST;
      enabled_q   <= 1'b0;
      now_q       <= '0;
      level_q     <= '1;
      edge_en_q   <= '1;
      block_q     <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        last_q[i] <= '0;
        hold_q[i] <= '0;
      end
    end else begin
      debounce_q  <= debounce_d;
      long_q      <= long_d;
      block_cfg_q <= block_cfg_d;
      enabled_q   <= enabled_d;
      now_q       <= now_d;
      level_q     <= level_d;
      edge_en_q   <= edge_en_d;
      block_q     <= block_d;
      last_q      <= last_d;
      hold_q      <= hold_d;
    end
  end

endmodule

// ===== rtl/button_press_classifier.sv =====
// Top level of the button press classifier: input register, core and
// output register with stream handshakes. Depends on bpc_pkg and bpc_core.
//
// Usage: the slave stream carries one transaction per 1 ms tick or per
// sampled level change. tuser selects the kind (0 tick, 1 level change);
// tdata carries the button index, the new level and the raw pin levels.
// The master stream carries one transaction for every reported press.
// Configuration is written through a plain write port; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// Writing 1 to the enable register also unmasks every button. An accepted
// transaction sits in the input register while the core updates its state,
// and any result is then loaded into the output register, from which the
// receiver takes it. One transaction is accepted every cycle unless the
// receiver stalls the output; the core updates its state combinationally.
// Reset clears all counters, marks every button released and unmasked, and
// loads the default timing values with edge acceptance off.
// When the receiver stalls, the result stays in the output register and the
// input register holds one further transaction; then tready drops.
module button_press_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Bits from lowest: button_index[1:0], level[2], pin_levels[5:3], rest unused.
  input  logic [bpc_pkg::S_DATA_W-1:0]        s_axis_tdata,
  // Bit 0: action (0 tick, 1 level change).
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Bits from lowest: press_button[1:0], press_type[2], by_timeout[3], zero.
  output logic [bpc_pkg::M_DATA_W-1:0]        m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [bpc_pkg::CFG_AW-1:0]          cfg_addr_i,
  input  logic [bpc_pkg::CFG_DW-1:0]          cfg_wdata_i
);
  import bpc_pkg::*;

  logic    stage_valid_q;
  item_t   stage_q, stage_d;
  logic    out_valid_q;
  result_t out_q;
  logic    proc;
  logic    core_res_valid;
  result_t core_res;

  assign proc          = stage_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !stage_valid_q || proc;

  always_comb begin
    stage_d.action       = act_e'(s_axis_tuser);
    stage_d.button_index = s_axis_tdata[BTN_IDX_W-1:0];
    stage_d.level        = s_axis_tdata[BTN_IDX_W];
    stage_d.pin_levels   = s_axis_tdata[BTN_IDX_W+PIN_W:BTN_IDX_W+1];
  end

  bpc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (proc),
    .item_i       (stage_q),
    .res_valid_o  (core_res_valid),
    .res_o        (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        stage_valid_q <= s_axis_tvalid;
      end
      if (proc && core_res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      stage_q <= stage_d;
    end
    if (proc && core_res_valid) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_DATA_W - BTN_IDX_W - 2){1'b0}},
                          out_q.by_timeout, out_q.press_type, out_q.press_button};

endmodule

// ===== rtl/bpc_checker.sv =====
// Port-level checks for the button press classifier, attached by bind.
// Depends on bpc_pkg and the button_press_classifier top level.
module bpc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bpc_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import bpc_pkg::*;

  a_button_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[BTN_IDX_W-1:0] < BTN_IDX_W'(BUTTONS)))
    else $error("Reported button index out of range.");

  a_timeout_long : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[BTN_IDX_W+1]) |-> (m_axis_tdata[BTN_IDX_W] == PRESS_LONG))
    else $error("Timeout report is not a long press.");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("Result appeared without an input transaction two cycles earlier.");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("Stalled result changed or vanished.");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
